/* src/bpg_pkg.sv */
// shared types and codes for the bezier patch grid evaluator
`default_nettype none
package bpg_pkg;

  localparam int IDX_W   = 10;
  localparam int FIELD_W = 32;
  localparam int N_W     = 4;
  localparam int CFG_W   = 5;
  localparam int CFG_IW  = 2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  localparam logic [CFG_IW-1:0] CFG_POINT_ROWS  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_POINT_COLS  = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_SUBDIV_LOG2 = 2'd2;

  typedef struct packed {
    logic                       op;
    logic [IDX_W-1:0]           row_index;
    logic [IDX_W-1:0]           col_index;
    logic signed [FIELD_W-1:0]  in_x;
    logic signed [FIELD_W-1:0]  in_y;
    logic signed [FIELD_W-1:0]  in_z;
    logic signed [FIELD_W-1:0]  in_s;
    logic signed [FIELD_W-1:0]  in_t;
  } in_item_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0]  out_x;
    logic signed [FIELD_W-1:0]  out_y;
    logic signed [FIELD_W-1:0]  out_z;
    logic signed [FIELD_W-1:0]  out_s;
    logic signed [FIELD_W-1:0]  out_t;
    logic                       index_error;
  } out_item_t;

endpackage
`default_nettype wire

/* src/bpg_ram.sv */
// generic single-port-write ram with registered read
`default_nettype none
module bpg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* src/bezier_patch_grid_evaluator.sv */
// biquadratic bezier patch grid evaluator top level
//
// A command channel (start/busy, in_item) carries write and evaluate items.
// A transaction is taken when start is high and busy is low.
// Write items store one control point (five Q16.16 components) and give a
// zero result with the error flag, if any, in the next cycle; busy stays low,
// so writes can be issued every cycle.
// Evaluate items read the nine control points of their 3x3 sub-surface from
// one memory, one per cycle, then round and saturate; busy is high from the
// transaction until the result appears. A weight state, the nine serial
// memory reads, draining the read/multiply/accumulate pipeline and a
// rounding state lie between the transaction and the result.
// An evaluate with an index out of range gives its error result in the next
// cycle without going busy.
// Each result is on out_item for one cycle with out_valid high; the receiver
// always takes it.
// The cfg port writes point_rows (0), point_cols (1) and subdiv_log2 (2);
// it is up to the user to write them only while the block is idle.
// Synchronous reset sets the registers to 3, 3 and 2 and returns to idle;
// the control point store holds no defined data until written.
`default_nettype none
module bezier_patch_grid_evaluator #(
  parameter int MAX_POINT_DIM   = 32,
  parameter int MAX_SUBDIV_LOG2 = 6,
  parameter int COORD_WIDTH     = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire bpg_pkg::in_item_t             in_item,
  output logic                               out_valid,
  output bpg_pkg::out_item_t                 out_item,
  input  wire logic                          cfg_we,
  input  wire logic [bpg_pkg::CFG_IW-1:0]    cfg_index,
  input  wire logic [bpg_pkg::CFG_W-1:0]     cfg_data
);

  localparam int CW    = COORD_WIDTH;
  localparam int DEPTH = MAX_POINT_DIM * MAX_POINT_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int EDW   = ($clog2(MAX_POINT_DIM) + 2 > 6) ? $clog2(MAX_POINT_DIM) + 2 : 6;
  localparam int LW    = 11 + MAX_SUBDIV_LOG2;
  localparam int KW    = MAX_SUBDIV_LOG2 + 1;
  localparam int WW    = 2 * MAX_SUBDIV_LOG2 + 1;
  localparam int PW    = 4 * MAX_SUBDIV_LOG2 + 1;
  localparam int MW    = CW + PW;
  localparam int ACW   = MW + 4;
  localparam int XW    = CW + 33;
  localparam int IW    = bpg_pkg::IDX_W;
  localparam int FW    = bpg_pkg::FIELD_W;
  localparam int NW    = bpg_pkg::N_W;

  typedef enum logic [2:0] {S_IDLE, S_WGT, S_RUN, S_DRAIN, S_FIN} state_t;

  state_t state_r;
  logic [bpg_pkg::CFG_W-1:0] rows_r, cols_r;
  logic [2:0]                subdiv_r;
  logic [KW-1:0]             kr_r, kc_r;
  logic [WW-1:0]             wr_r [3];
  logic [WW-1:0]             wc_r [3];
  logic [1:0]                i_r, j_r;
  logic [AW:0]               row_addr_r;
  logic [PW-1:0]             w_q_r;
  logic                      v1_r, v2_r;
  logic [MW-1:0]             prod_r [5];
  logic [ACW-1:0]            acc_r [5];
  logic                      out_valid_r;
  bpg_pkg::out_item_t        out_item_r;

  logic [EDW-1:0]  rows_eff, cols_eff;
  logic [NW-1:0]   n_eff;
  logic            accept, is_write, wr_ok, ev_err;
  logic [LW-1:0]   lim_r, lim_c;
  logic [IW-1:0]   sr, sc;
  logic [5*CW-1:0] wdata, rdata;
  logic [AW-1:0]   waddr, raddr;
  logic            ram_we;

  function automatic logic [CW-1:0] sat_in(input logic signed [FW-1:0] v);
    logic signed [XW-1:0] vx, hi, lo;
    vx = XW'(v);
    hi = XW'(1) <<< (CW - 1);
    hi = hi - XW'(1);
    lo = -hi - XW'(1);
    if (vx > hi) begin
      return hi[CW-1:0];
    end else if (vx < lo) begin
      return lo[CW-1:0];
    end
    return vx[CW-1:0];
  endfunction

  // round by 2^(4n), clamp to the offset range, back to signed, then to 32 bits
  function automatic logic [FW-1:0] finish(input logic [ACW-1:0] acc,
                                            input logic [NW-1:0] n);
    logic [ACW-1:0] half, rnd, cap;
    logic [CW-1:0] u;
    logic signed [XW-1:0] sx, hi, lo;
    half = (n != '0) ? (ACW'(1) << (4 * n - 1)) : '0;
    rnd  = (acc + half) >> (4 * n);
    cap  = (ACW'(1) << CW) - ACW'(1);
    u    = (rnd > cap) ? cap[CW-1:0] : rnd[CW-1:0];
    sx   = XW'($signed({~u[CW-1], u[CW-2:0]}));
    hi   = XW'(64'sh7fffffff);
    lo   = -hi - XW'(1);
    if (sx > hi) begin
      return hi[FW-1:0];
    end else if (sx < lo) begin
      return lo[FW-1:0];
    end
    return sx[FW-1:0];
  endfunction

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign is_write = (in_item.op == bpg_pkg::OP_WRITE);

  always_comb begin
    rows_eff = (rows_r < 5'd3) ? EDW'(3) : EDW'(rows_r);
    if (rows_eff > EDW'(MAX_POINT_DIM)) rows_eff = EDW'(MAX_POINT_DIM);
    cols_eff = (cols_r < 5'd3) ? EDW'(3) : EDW'(cols_r);
    if (cols_eff > EDW'(MAX_POINT_DIM)) cols_eff = EDW'(MAX_POINT_DIM);
    n_eff = ({1'b0, subdiv_r} > NW'(MAX_SUBDIV_LOG2)) ? NW'(MAX_SUBDIV_LOG2)
                                                       : {1'b0, subdiv_r};
  end

  assign wr_ok = (in_item.row_index < IW'(rows_eff)) && (in_item.col_index < IW'(cols_eff));
  assign lim_r = (LW'((rows_eff - EDW'(1)) >> 1) << n_eff) + LW'(1);
  assign lim_c = (LW'((cols_eff - EDW'(1)) >> 1) << n_eff) + LW'(1);
  assign ev_err = (LW'(in_item.row_index) >= lim_r) || (LW'(in_item.col_index) >= lim_c);
  assign sr = ((in_item.row_index != '0) ? in_item.row_index - IW'(1) : '0) >> n_eff;
  assign sc = ((in_item.col_index != '0) ? in_item.col_index - IW'(1) : '0) >> n_eff;

  assign ram_we = accept && is_write && wr_ok;
  assign waddr  = AW'(AW'(in_item.row_index) * AW'(MAX_POINT_DIM) + AW'(in_item.col_index));
  assign wdata  = {sat_in(in_item.in_t), sat_in(in_item.in_s), sat_in(in_item.in_z),
                   sat_in(in_item.in_y), sat_in(in_item.in_x)};
  assign raddr  = AW'(row_addr_r + (AW + 1)'(j_r));

  bpg_ram #(.WIDTH(5 * CW), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // multiply and accumulate pipeline: the registered read data lines up with the registered w_q
  always_ff @(posedge clk) begin
    if (v1_r) begin
      for (int c = 0; c < 5; c++) begin
        prod_r[c] <= MW'({~rdata[c*CW + CW - 1], rdata[c*CW +: CW-1]}) * MW'(w_q_r);
      end
    end
    if (state_r == S_WGT) begin
      for (int c = 0; c < 5; c++) acc_r[c] <= '0;
    end else if (v2_r) begin
      for (int c = 0; c < 5; c++) acc_r[c] <= acc_r[c] + ACW'(prod_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rows_r      <= 5'd3;
      cols_r      <= 5'd3;
      subdiv_r    <= 3'd2;
      out_valid_r <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
    end else begin
      out_valid_r <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= v1_r;
      if (cfg_we) begin
        unique case (cfg_index)
          bpg_pkg::CFG_POINT_ROWS:  rows_r   <= cfg_data;
          bpg_pkg::CFG_POINT_COLS:  cols_r   <= cfg_data;
          bpg_pkg::CFG_SUBDIV_LOG2: subdiv_r <= cfg_data[2:0];
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (is_write) begin
              out_valid_r <= 1'b1;
              out_item_r  <= '{index_error: !wr_ok, default: '0};
            end else if (ev_err) begin
              out_valid_r <= 1'b1;
              out_item_r  <= '{index_error: 1'b1, default: '0};
            end else begin
              kr_r       <= KW'(in_item.row_index - (sr << n_eff));
              kc_r       <= KW'(in_item.col_index - (sc << n_eff));
              row_addr_r <= (AW + 1)'((AW + 1)'(sr) * (AW + 1)'(2 * MAX_POINT_DIM)
                                      + (AW + 1)'(sc) * (AW + 1)'(2));
              i_r        <= '0;
              j_r        <= '0;
              state_r    <= S_WGT;
            end
          end
        end
        S_WGT: begin
          wr_r[0] <= WW'((KW'(1) << n_eff) - kr_r) * WW'((KW'(1) << n_eff) - kr_r);
          wr_r[1] <= WW'(WW'((KW'(1) << n_eff) - kr_r) * WW'(kr_r)) << 1;
          wr_r[2] <= WW'(kr_r) * WW'(kr_r);
          wc_r[0] <= WW'((KW'(1) << n_eff) - kc_r) * WW'((KW'(1) << n_eff) - kc_r);
          wc_r[1] <= WW'(WW'((KW'(1) << n_eff) - kc_r) * WW'(kc_r)) << 1;
          wc_r[2] <= WW'(kc_r) * WW'(kc_r);
          state_r <= S_RUN;
        end
        S_RUN: begin
          w_q_r <= PW'(wr_r[i_r]) * PW'(wc_r[j_r]);
          v1_r  <= 1'b1;
          if (j_r == 2'd2) begin
            j_r        <= '0;
            i_r        <= i_r + 2'd1;
            row_addr_r <= row_addr_r + (AW + 1)'(MAX_POINT_DIM);
            if (i_r == 2'd2) state_r <= S_DRAIN;
          end else begin
            j_r <= j_r + 2'd1;
          end
        end
        S_DRAIN: begin
          if (!v1_r && !v2_r) state_r <= S_FIN;
        end
        S_FIN: begin
          out_valid_r <= 1'b1;
          out_item_r  <= '{out_x:       finish(acc_r[0], n_eff),
                           out_y:       finish(acc_r[1], n_eff),
                           out_z:       finish(acc_r[2], n_eff),
                           out_s:       finish(acc_r[3], n_eff),
                           out_t:       finish(acc_r[4], n_eff),
                           index_error: 1'b0};
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

/* src/bpg_checker.sv */
// port-level checks for the bezier patch grid evaluator, bound to the top level
`default_nettype none
module bpg_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire bpg_pkg::in_item_t  in_item,
  input wire logic               out_valid,
  input wire bpg_pkg::out_item_t out_item
);

  // a write transaction answers the next cycle with zero out_x and out_t
  a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_item.op == bpg_pkg::OP_WRITE |=>
      out_valid && out_item.out_x == '0 && out_item.out_t == '0)
    else $error("write transaction without a zero result");

  // an evaluate either errors out at once or occupies the block
  a_eval_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_item.op == bpg_pkg::OP_EVAL |=> out_valid || busy)
    else $error("evaluate transaction dropped");

  // error results carry zero values
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.index_error |->
      out_item.out_x == '0 && out_item.out_y == '0 && out_item.out_z == '0 &&
      out_item.out_s == '0 && out_item.out_t == '0)
    else $error("error result with nonzero values");

  // no result while an evaluation is running
  a_no_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_valid)
    else $error("result strobe while busy");

endmodule

bind bezier_patch_grid_evaluator bpg_checker u_bpg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);
`default_nettype wire

/* bench/tb.sv */
// testbench for the bezier patch grid evaluator: scoreboard, drivers and stimulus
`timescale 1ns / 100ps
`default_nettype none
module tb;

  class patch_scoreboard;
    int pts[5][1024];
    int unsigned rows_reg = 3, cols_reg = 3, subdiv_reg = 2;
    bpg_pkg::out_item_t expected_results[$];
    int fails = 0;

    function int unsigned eff_dim(int unsigned v);
      if (v < 3) return 3;
      if (v > 32) return 32;
      return v;
    endfunction

    function int unsigned eff_subdiv();
      return (subdiv_reg > 6) ? 6 : subdiv_reg;
    endfunction

    // largest grid index + 1 along one side
    function int unsigned grid_span(int unsigned dim_reg);
      return ((eff_dim(dim_reg) - 1) / 2) * (1 << eff_subdiv()) + 1;
    endfunction

    function logic [31:0] blend(int comp, int unsigned base, longint wr[3], longint wc[3],
                                int unsigned m);
      longint acc;
      acc = 0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          acc += wr[i] * wc[j] * longint'(pts[comp][(base + i * 32 + j) % 1024]);
      if (m > 0) acc += longint'(1) << (m - 1);
      acc = acc >>> m;
      if (acc > 64'sh7fffffff) acc = 64'sh7fffffff;
      if (acc < -64'sh80000000) acc = -64'sh80000000;
      return acc[31:0];
    endfunction

    function void note(bpg_pkg::in_item_t it);
      bpg_pkg::out_item_t e;
      int unsigned r, c, n, q, sr, sc, kr, kc, base;
      longint wr[3], wc[3];
      e = '0;
      r = it.row_index;
      c = it.col_index;
      if (it.op == bpg_pkg::OP_WRITE) begin
        if (r >= eff_dim(rows_reg) || c >= eff_dim(cols_reg)) begin
          e.index_error = 1'b1;
        end else begin
          pts[0][r * 32 + c] = it.in_x;
          pts[1][r * 32 + c] = it.in_y;
          pts[2][r * 32 + c] = it.in_z;
          pts[3][r * 32 + c] = it.in_s;
          pts[4][r * 32 + c] = it.in_t;
        end
      end else if (r >= grid_span(rows_reg) || c >= grid_span(cols_reg)) begin
        e.index_error = 1'b1;
      end else begin
        n = eff_subdiv();
        q = 1 << n;
        // shared edge points belong to the earlier surface
        sr = (r > 0 ? r - 1 : 0) >> n;
        sc = (c > 0 ? c - 1 : 0) >> n;
        kr = r - (sr << n);
        kc = c - (sc << n);
        wr[0] = (q - kr) * (q - kr); wr[1] = 2 * kr * (q - kr); wr[2] = kr * kr;
        wc[0] = (q - kc) * (q - kc); wc[1] = 2 * kc * (q - kc); wc[2] = kc * kc;
        base = 2 * sr * 32 + 2 * sc;
        e.out_x = blend(0, base, wr, wc, 4 * n);
        e.out_y = blend(1, base, wr, wc, 4 * n);
        e.out_z = blend(2, base, wr, wc, 4 * n);
        e.out_s = blend(3, base, wr, wc, 4 * n);
        e.out_t = blend(4, base, wr, wc, 4 * n);
      end
      expected_results = {expected_results, e};
    endfunction

    function void check(bpg_pkg::out_item_t got);
      bpg_pkg::out_item_t e;
      if (expected_results.size() == 0) begin
        $error("unexpected transaction %h", got);
        fails++;
        return;
      end
      e = expected_results.pop_front();
      if (got.out_x !== e.out_x) begin
        $error("out_x exp %h got %h", e.out_x, got.out_x); fails++;
      end
      if (got.out_y !== e.out_y) begin
        $error("out_y exp %h got %h", e.out_y, got.out_y); fails++;
      end
      if (got.out_z !== e.out_z) begin
        $error("out_z exp %h got %h", e.out_z, got.out_z); fails++;
      end
      if (got.out_s !== e.out_s) begin
        $error("out_s exp %h got %h", e.out_s, got.out_s); fails++;
      end
      if (got.out_t !== e.out_t) begin
        $error("out_t exp %h got %h", e.out_t, got.out_t); fails++;
      end
      if (got.index_error !== e.index_error) begin
        $error("index_error exp %b got %b", e.index_error, got.index_error); fails++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  bpg_pkg::in_item_t in_item = '0;
  logic out_valid;
  bpg_pkg::out_item_t out_item;
  logic cfg_we = 0;
  logic [bpg_pkg::CFG_IW-1:0] cfg_index = bpg_pkg::CFG_POINT_ROWS;
  logic [bpg_pkg::CFG_W-1:0] cfg_data = '0;

  patch_scoreboard sb = new();
  int idle_pct = 29;

  always #1 clk = ~clk;

  bezier_patch_grid_evaluator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check(out_item);
  end

  initial begin
    #2ms;
    $display("[bezier_patch_grid_evaluator] ERROR");
    $finish;
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      default: return $urandom;
    endcase
  endfunction

  function automatic bpg_pkg::in_item_t make_item(logic op, int unsigned r, int unsigned c);
    bpg_pkg::in_item_t it;
    it.op = op;
    it.row_index = bpg_pkg::IDX_W'(r);
    it.col_index = bpg_pkg::IDX_W'(c);
    it.in_x = rand_coord();
    it.in_y = rand_coord();
    it.in_z = rand_coord();
    it.in_s = rand_coord();
    it.in_t = rand_coord();
    return it;
  endfunction

  // called and returns at a falling edge
  task automatic send(bpg_pkg::in_item_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    sb.note(it);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [bpg_pkg::CFG_IW-1:0] idx, int unsigned val);
    start <= 1'b0;
    while (sb.expected_results.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= bpg_pkg::CFG_W'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == bpg_pkg::CFG_POINT_ROWS) sb.rows_reg = val & 32'h1f;
    else if (idx == bpg_pkg::CFG_POINT_COLS) sb.cols_reg = val & 32'h1f;
    else sb.subdiv_reg = val & 32'h7;
  endtask

  task automatic fill_grid();
    for (int r = 0; r < sb.eff_dim(sb.rows_reg); r++)
      for (int c = 0; c < sb.eff_dim(sb.cols_reg); c++)
        send(make_item(bpg_pkg::OP_WRITE, r, c));
  endtask

  task automatic random_items(int count);
    int unsigned gr, gc, sel;
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        gr = $urandom_range(0, sb.grid_span(sb.rows_reg) - 1);
        gc = $urandom_range(0, sb.grid_span(sb.cols_reg) - 1);
        send(make_item(bpg_pkg::OP_EVAL, gr, gc));
      end else if (sel < 85) begin
        send(make_item(bpg_pkg::OP_WRITE, $urandom_range(0, sb.eff_dim(sb.rows_reg) - 1),
                       $urandom_range(0, sb.eff_dim(sb.cols_reg) - 1)));
      end else begin
        // mostly out of range, any op
        send(make_item(1'($urandom_range(0, 1)), $urandom_range(0, 1023),
                       $urandom_range(0, 1023)));
      end
    end
  endtask

  initial begin
    int unsigned cfgs[7][3] = '{'{3, 3, 2}, '{5, 7, 0}, '{31, 3, 6}, '{0, 2, 7},
                                 '{4, 6, 3}, '{9, 5, 1}, '{3, 31, 5}};
    bpg_pkg::in_item_t it;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset configuration
    fill_grid();
    it = make_item(bpg_pkg::OP_WRITE, 1, 1);
    it.in_x = 32'h7fffffff; it.in_y = 32'h80000000; it.in_z = '0;
    it.in_s = 32'hffffffff; it.in_t = 32'h00010000;
    send(it);
    send(make_item(bpg_pkg::OP_EVAL, 0, 0));
    send(make_item(bpg_pkg::OP_EVAL, 4, 4));
    send(make_item(bpg_pkg::OP_EVAL, 2, 3));
    send(make_item(bpg_pkg::OP_EVAL, 5, 0));
    send(make_item(bpg_pkg::OP_EVAL, 0, 5));
    send(make_item(bpg_pkg::OP_EVAL, 1023, 1023));
    send(make_item(bpg_pkg::OP_WRITE, 3, 0));
    send(make_item(bpg_pkg::OP_WRITE, 0, 3));
    send(make_item(bpg_pkg::OP_WRITE, 1023, 1023));

    for (int p = 0; p < 7; p++) begin
      if (p > 0) begin
        write_reg(bpg_pkg::CFG_POINT_ROWS, cfgs[p][0]);
        write_reg(bpg_pkg::CFG_POINT_COLS, cfgs[p][1]);
        write_reg(bpg_pkg::CFG_SUBDIV_LOG2, cfgs[p][2]);
        fill_grid();
      end
      // one phase with no idling at all
      idle_pct = (p == 2) ? 0 : 29;
      random_items(p == 2 ? 100 : 75);
    end

    start <= 1'b0;
    while (sb.expected_results.size() != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (sb.fails == 0) begin
      $display("[bezier_patch_grid_evaluator] OK");
    end else begin
      $display("[bezier_patch_grid_evaluator] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
